// ===== hdl/dlps_pkg.sv =====
// dlps_pkg: types, register codes and constant table functions for the
// directional light phong shader. No dependencies.
package dlps_pkg;

  typedef enum logic [2:0] {
    CFG_LIGHT_DIR_X  = 3'd0,
    CFG_LIGHT_DIR_Y  = 3'd1,
    CFG_LIGHT_DIR_Z  = 3'd2,
    CFG_LIGHT_COLOUR = 3'd3,
    CFG_EYE_X        = 3'd4,
    CFG_EYE_Y        = 3'd5,
    CFG_EYE_Z        = 3'd6
  } cfg_reg_t;

  localparam int          CFG_IDX_W      = 3;
  localparam logic [15:0] ONE_Q14        = 16'd16384;
  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [47:0] LIGHT_COL_RST  = 48'hFFFF_FFFF_FFFF;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic [2:0][15:0] amb;
    logic [2:0][19:0] dif;
    logic [2:0][15:0] spc;
    logic [15:0]      shadow;
    logic [23:0]      pwr;
    logic [2:0][15:0] nrm;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][29:0] mn;
  } ctx_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = v;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // log2 of mantissa x0 (Q2.30 in [1,2)), result Q.16
  function automatic logic [15:0] log_entry(input logic [63:0] x0);
    logic [63:0] x;
    logic [15:0] r;
    x = x0;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return r;
  endfunction

  // 2^-f for fraction f (Q.16), result Q1.16
  function automatic logic [16:0] exp_entry(input logic [63:0] f);
    logic [63:0] c [16];
    logic [63:0] acc;
    c[0] = isqrt64(64'd1 << 59);
    for (int k = 1; k < 16; k++) begin
      c[k] = isqrt64(c[k-1] << 30);
    end
    acc = 64'd1 << 30;
    for (int k = 0; k < 16; k++) begin
      if (f[15-k]) begin
        acc = (acc * c[k]) >> 30;
      end
    end
    return 17'(acc >> 14);
  endfunction

  // arithmetic shift right by 14, rounding toward zero
  function automatic logic signed [47:0] shr_tz14(input logic signed [47:0] v);
    logic [47:0] m;
    m = v[47] ? 48'(-v) : 48'(v);
    m = m >> 14;
    return v[47] ? -$signed(m) : $signed(m);
  endfunction

endpackage

// ===== hdl/directional_light_phong_shader.sv =====
// directional_light_phong_shader: fully pipelined phong shading of one ray hit
// under a directional light. Depends on dlps_pkg.
//
// Usage:
//   Input channel in_valid/in_stall carries one request per ray hit: albedo,
//   material coefficients, unit normal, hit position and shadow factor.
//   Result channel out_valid/out_stall returns red, green, blue in Q4.12,
//   saturated. Every request gives exactly one result, in order.
//   Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data writes light
//   direction, light colour and eye position; cfg_ready is always high and
//   writes are meant for times when no request is in flight.
//   One request can be taken every cycle while the pipeline is not held; the
//   rate is one per cycle, set by a single pipeline whose longest parts are
//   the 16-stage square root (two bits per stage) and the 8-stage divider
//   (two quotient bits per stage).
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and loads the register defaults:
//   light direction (0, 0, 1.0), white light, eye at the origin.
module directional_light_phong_shader
  import dlps_pkg::*;
#(
  parameter int POW_TABLE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [47:0]          in_albedo_rgb,
  input  logic [15:0]          in_ambient_coef,
  input  logic [15:0]          in_diffuse_coef,
  input  logic [15:0]          in_specular_coef,
  input  logic [15:0]          in_roughness,
  input  logic signed [15:0]   in_normal_x,
  input  logic signed [15:0]   in_normal_y,
  input  logic signed [15:0]   in_normal_z,
  input  logic signed [31:0]   in_hit_x,
  input  logic signed [31:0]   in_hit_y,
  input  logic signed [31:0]   in_hit_z,
  input  logic [15:0]          in_shadow_factor,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [15:0]          out_red,
  output logic [15:0]          out_green,
  output logic [15:0]          out_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]          cfg_data
);

  localparam int IDX_W    = $clog2(POW_TABLE_ENTRIES);
  localparam int MW       = 13 + IDX_W + 1;
  localparam int EW       = 16 + IDX_W + 1;
  localparam int NS       = 39;
  localparam int SQRT_STG = 16;
  localparam int DIV_STG  = 8;
  localparam int K_SQ     = 1;
  localparam int K_SUM    = 2;
  localparam int K_SQRT   = 3;
  localparam int K_DIV    = K_SQRT + SQRT_STG;
  localparam int K_U      = K_DIV + DIV_STG;
  localparam int K_VN     = K_U + 1;
  localparam int K_VNN    = K_U + 2;
  localparam int K_R      = K_U + 3;
  localparam int K_RLP    = K_U + 4;
  localparam int K_RL     = K_U + 5;
  localparam int K_P1     = K_U + 6;
  localparam int K_P2     = K_U + 7;
  localparam int K_P3     = K_U + 8;
  localparam int K_P4     = K_U + 9;
  localparam int K_S      = K_U + 10;
  localparam int K_M      = K_U + 11;

  // configuration
  logic [15:0] ldir_r [3];
  logic [31:0] eye_r [3];
  logic [47:0] light_colour_r;
  logic signed [16:0] lneg [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldir_r[0]      <= '0;
      ldir_r[1]      <= '0;
      ldir_r[2]      <= ONE_Q14;
      light_colour_r <= LIGHT_COL_RST;
      eye_r[0]       <= '0;
      eye_r[1]       <= '0;
      eye_r[2]       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIGHT_DIR_X:  ldir_r[0]      <= cfg_data[15:0];
        CFG_LIGHT_DIR_Y:  ldir_r[1]      <= cfg_data[15:0];
        CFG_LIGHT_DIR_Z:  ldir_r[2]      <= cfg_data[15:0];
        CFG_LIGHT_COLOUR: light_colour_r <= cfg_data;
        CFG_EYE_X:        eye_r[0]       <= cfg_data[31:0];
        CFG_EYE_Y:        eye_r[1]       <= cfg_data[31:0];
        CFG_EYE_Z:        eye_r[2]       <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lneg[i] = -$signed({ldir_r[i][15], ldir_r[i]});
    end
  end

  // power tables
  logic [15:0] log_tab [POW_TABLE_ENTRIES];
  logic [16:0] exp_tab [POW_TABLE_ENTRIES];

  for (genvar g = 0; g < POW_TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [63:0] LogX = (64'd1 << 30) + ((64'(g) << 30) / POW_TABLE_ENTRIES);
    localparam logic [63:0] ExpF = (64'(g) << 16) / POW_TABLE_ENTRIES;
    assign log_tab[g] = log_entry(LogX);
    assign exp_tab[g] = exp_entry(ExpF);
  end

  // pipeline advance
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 0: input register
  logic        s0_v_r;
  logic [47:0] s0_alb_r;
  logic [15:0] s0_amb_r, s0_dif_r, s0_spc_r, s0_rough_r, s0_shadow_r;
  logic [15:0] s0_nrm_r [3];
  logic [31:0] s0_hit_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_alb_r    <= in_albedo_rgb;
      s0_amb_r    <= in_ambient_coef;
      s0_dif_r    <= in_diffuse_coef;
      s0_spc_r    <= in_specular_coef;
      s0_rough_r  <= in_roughness;
      s0_shadow_r <= in_shadow_factor;
      s0_nrm_r[0] <= in_normal_x;
      s0_nrm_r[1] <= in_normal_y;
      s0_nrm_r[2] <= in_normal_z;
      s0_hit_r[0] <= in_hit_x;
      s0_hit_r[1] <= in_hit_y;
      s0_hit_r[2] <= in_hit_z;
    end
  end

  // stage 1: view vector, light dot products, coefficient products
  logic signed [32:0] vraw [3];
  logic [15:0]        alb_c [3];
  logic [15:0]        lc_c [3];
  logic               s1_v_r;
  logic [2:0]         s1_neg_nxt, s1_neg_r;
  logic [31:0]        s1_mag_nxt [3], s1_mag_r [3];
  logic signed [32:0] s1_dp_nxt [3], s1_dp_r [3];
  logic [15:0]        s1_amb_nxt [3], s1_amb_r [3];
  logic [15:0]        s1_difp_nxt [3], s1_difp_r [3];
  logic [15:0]        s1_spc_nxt [3], s1_spc_r [3];
  logic [23:0]        s1_pwr_nxt, s1_pwr_r;
  logic [15:0]        s1_nrm_r [3];
  logic [15:0]        s1_shadow_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vraw[i] = $signed({s0_hit_r[i][31], s0_hit_r[i]}) - $signed({eye_r[i][31], eye_r[i]});
      s1_neg_nxt[i] = vraw[i][32];
      s1_mag_nxt[i] = vraw[i][32] ? 32'(-vraw[i]) : vraw[i][31:0];
      s1_dp_nxt[i]  = 33'(lneg[i]) * 33'($signed(s0_nrm_r[i]));
      alb_c[i]      = s0_alb_r[32-16*i +: 16];
      lc_c[i]       = light_colour_r[32-16*i +: 16];
      s1_amb_nxt[i]  = 16'((32'(alb_c[i]) * 32'(s0_amb_r)) >> 16);
      s1_difp_nxt[i] = 16'((32'(alb_c[i]) * 32'(s0_dif_r)) >> 16);
      s1_spc_nxt[i]  = 16'((32'(lc_c[i]) * 32'(s0_spc_r)) >> 16);
    end
    s1_pwr_nxt = 24'((25'(ONE_Q16 - 17'(s0_rough_r)) * 25'd254) + 25'(ONE_Q16));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r    <= s1_neg_nxt;
      s1_mag_r    <= s1_mag_nxt;
      s1_dp_r     <= s1_dp_nxt;
      s1_amb_r    <= s1_amb_nxt;
      s1_difp_r   <= s1_difp_nxt;
      s1_spc_r    <= s1_spc_nxt;
      s1_pwr_r    <= s1_pwr_nxt;
      s1_nrm_r    <= s0_nrm_r;
      s1_shadow_r <= s0_shadow_r;
    end
  end

  // stage 2: diffuse term, leading one of largest magnitude
  logic signed [34:0] dot_sum;
  logic [31:0]        mx;
  logic               s2_v_r;
  logic [17:0]        s2_ld_nxt, s2_ld_r;
  logic [4:0]         s2_pos_nxt, s2_pos_r;
  logic               s2_zero_r;
  logic [2:0]         s2_neg_r;
  logic [31:0]        s2_mag_r [3];
  logic [15:0]        s2_amb_r [3], s2_difp_r [3], s2_spc_r [3], s2_nrm_r [3];
  logic [23:0]        s2_pwr_r;
  logic [15:0]        s2_shadow_r;

  always_comb begin
    dot_sum   = 35'(s1_dp_r[0]) + 35'(s1_dp_r[1]) + 35'(s1_dp_r[2]);
    s2_ld_nxt = (dot_sum > 0) ? dot_sum[31:14] : '0;
    mx = s1_mag_r[0];
    if (s1_mag_r[1] > mx) begin
      mx = s1_mag_r[1];
    end
    if (s1_mag_r[2] > mx) begin
      mx = s1_mag_r[2];
    end
    s2_pos_nxt = '0;
    for (int b = 0; b < 32; b++) begin
      if (mx[b]) begin
        s2_pos_nxt = 5'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ld_r     <= s2_ld_nxt;
      s2_pos_r    <= s2_pos_nxt;
      s2_zero_r   <= (mx == '0);
      s2_neg_r    <= s1_neg_r;
      s2_mag_r    <= s1_mag_r;
      s2_amb_r    <= s1_amb_r;
      s2_difp_r   <= s1_difp_r;
      s2_spc_r    <= s1_spc_r;
      s2_nrm_r    <= s1_nrm_r;
      s2_pwr_r    <= s1_pwr_r;
      s2_shadow_r <= s1_shadow_r;
    end
  end

  // stage 3 onward: context pipeline
  ctx_t ctx0_nxt;
  ctx_t ctx_r [NS];
  logic vk_r [NS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ctx0_nxt.amb[i] = s2_amb_r[i];
      ctx0_nxt.dif[i] = 20'((34'(s2_difp_r[i]) * 34'(s2_ld_r)) >> 14);
      ctx0_nxt.spc[i] = s2_spc_r[i];
      ctx0_nxt.nrm[i] = s2_nrm_r[i];
      ctx0_nxt.mn[i]  = (s2_pos_r >= 5'd29) ? 30'(s2_mag_r[i] >> (s2_pos_r - 5'd29))
                                            : 30'(s2_mag_r[i] << (5'd29 - s2_pos_r));
    end
    ctx0_nxt.shadow = s2_shadow_r;
    ctx0_nxt.pwr    = s2_pwr_r;
    ctx0_nxt.neg    = s2_neg_r;
    ctx0_nxt.zero   = s2_zero_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx0_nxt;
      for (int k = 1; k < NS; k++) begin
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        vk_r[k] <= 1'b0;
      end
    end else if (adv) begin
      s0_v_r      <= in_valid;
      s1_v_r      <= s0_v_r;
      s2_v_r      <= s1_v_r;
      vk_r[0]     <= s2_v_r;
      out_valid_r <= vk_r[NS-1];
      for (int k = 1; k < NS; k++) begin
        vk_r[k] <= vk_r[k-1];
      end
    end
  end

  // squared length
  logic [59:0] sq_r [3];
  logic [61:0] ssum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 60'(ctx_r[K_SQ-1].mn[i]) * 60'(ctx_r[K_SQ-1].mn[i]);
      end
      ssum_r <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
    end
  end

  // square root, two result bits per stage
  logic [62:0] sqx_r [SQRT_STG];
  logic [62:0] sqres_r [SQRT_STG];

  for (genvar j = 0; j < SQRT_STG; j++) begin : g_sqrt
    localparam logic [62:0] Bit0 = 63'd1 << (62 - 4*j);
    localparam logic [62:0] Bit1 = 63'd1 << (60 - 4*j);
    logic [62:0] x0, r0, x1, r1, x2, r2;
    if (j == 0) begin : g_first
      assign x0 = 63'(ssum_r);
      assign r0 = '0;
    end else begin : g_next
      assign x0 = sqx_r[j-1];
      assign r0 = sqres_r[j-1];
    end
    always_comb begin
      if (x0 >= r0 + Bit0) begin
        x1 = x0 - (r0 + Bit0);
        r1 = (r0 >> 1) + Bit0;
      end else begin
        x1 = x0;
        r1 = r0 >> 1;
      end
      if (x1 >= r1 + Bit1) begin
        x2 = x1 - (r1 + Bit1);
        r2 = (r1 >> 1) + Bit1;
      end else begin
        x2 = x1;
        r2 = r1 >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqx_r[j]   <= x2;
        sqres_r[j] <= r2;
      end
    end
  end

  // division of each magnitude by the length, two quotient bits per stage
  logic [45:0] drem_r [DIV_STG][3];
  logic [15:0] dq_r [DIV_STG][3];
  logic [30:0] dlen_r [DIV_STG];

  for (genvar j = 0; j < DIV_STG; j++) begin : g_div
    localparam int J0 = 15 - 2*j;
    localparam int J1 = 14 - 2*j;
    logic [30:0] lin;
    logic [45:0] rin [3];
    logic [15:0] qin [3];
    logic [45:0] rmid [3], rout [3];
    logic [15:0] qmid [3], qout [3];
    logic [45:0] d0, d1;
    if (j == 0) begin : g_first
      assign lin = sqres_r[SQRT_STG-1][30:0];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rin[i] = 46'({ctx_r[K_DIV-1].mn[i], 14'd0});
        assign qin[i] = '0;
      end
    end else begin : g_next
      assign lin = dlen_r[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rin[i] = drem_r[j-1][i];
        assign qin[i] = dq_r[j-1][i];
      end
    end
    assign d0 = 46'(lin) << J0;
    assign d1 = 46'(lin) << J1;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (rin[i] >= d0) begin
          rmid[i] = rin[i] - d0;
          qmid[i] = qin[i] | (16'd1 << J0);
        end else begin
          rmid[i] = rin[i];
          qmid[i] = qin[i];
        end
        if (rmid[i] >= d1) begin
          rout[i] = rmid[i] - d1;
          qout[i] = qmid[i] | (16'd1 << J1);
        end else begin
          rout[i] = rmid[i];
          qout[i] = qmid[i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dlen_r[j] <= lin;
        for (int i = 0; i < 3; i++) begin
          drem_r[j][i] <= rout[i];
          dq_r[j][i]   <= qout[i];
        end
      end
    end
  end

  // reflection vector and its dot with the light
  logic signed [15:0] u_nxt [3];
  logic signed [15:0] u_a_r [3], u_b_r [3], u_c_r [3];
  logic signed [31:0] un_r [3];
  logic signed [17:0] vn_r;
  logic signed [34:0] pn_r [3];
  logic signed [21:0] r_r [3];
  logic signed [38:0] rlp_r [3];
  logic signed [22:0] rl_r;
  logic signed [47:0] vn_full, rl_full;
  logic signed [47:0] pn_sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_nxt[i] = ctx_r[K_U-1].neg[i] ? -$signed(dq_r[DIV_STG-1][i])
                                     : $signed(dq_r[DIV_STG-1][i]);
      pn_sh[i] = shr_tz14(48'(pn_r[i]));
    end
    vn_full = shr_tz14(48'(un_r[0]) + 48'(un_r[1]) + 48'(un_r[2]));
    rl_full = shr_tz14(48'(rlp_r[0]) + 48'(rlp_r[1]) + 48'(rlp_r[2]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_a_r[i] <= u_nxt[i];
        un_r[i]  <= 32'(u_nxt[i]) * 32'($signed(ctx_r[K_U-1].nrm[i]));
        u_b_r[i] <= u_a_r[i];
        u_c_r[i] <= u_b_r[i];
        pn_r[i]  <= 35'(vn_r) * 35'($signed(ctx_r[K_VNN-1].nrm[i])) * 35'sd2;
        r_r[i]   <= 22'(u_c_r[i]) - 22'(pn_sh[i]);
        rlp_r[i] <= 39'(r_r[i]) * 39'(lneg[i]);
      end
      vn_r <= 18'(vn_full);
      rl_r <= 23'(rl_full);
    end
  end

  // power through log2 and exp2 tables
  logic        p1_z_r, p1_one_r, p2_z_r, p2_one_r, p3_z_r, p3_one_r;
  logic [3:0]  p1_e_nxt, p1_e_r;
  logic [13:0] p1_m_r;
  logic [19:0] p2_neg_r;
  logic [27:0] p3_t_r;
  logic [16:0] fac_nxt, fac_r;
  logic [MW-1:0] lprod;
  logic [EW-1:0] eprod;
  logic [11:0]   ti;

  always_comb begin
    p1_e_nxt = '0;
    for (int b = 0; b < 14; b++) begin
      if (rl_r[b]) begin
        p1_e_nxt = 4'(b);
      end
    end
    lprod = MW'(p1_m_r[12:0]) * MW'(POW_TABLE_ENTRIES);
    eprod = EW'(p3_t_r[15:0]) * EW'(POW_TABLE_ENTRIES);
    ti    = p3_t_r[27:16];
    priority if (p3_z_r || ctx_r[K_P4-1].zero) begin
      fac_nxt = '0;
    end else if (p3_one_r) begin
      fac_nxt = ONE_Q16;
    end else if (ti > 12'd16) begin
      fac_nxt = '0;
    end else begin
      fac_nxt = exp_tab[eprod[16 +: IDX_W]] >> ti;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_z_r   <= (rl_r <= 0);
      p1_one_r <= (rl_r >= $signed(23'(ONE_Q14)));
      p1_e_r   <= p1_e_nxt;
      p1_m_r   <= 14'(rl_r[13:0] << (4'd13 - p1_e_nxt));
      p2_z_r   <= p1_z_r;
      p2_one_r <= p1_one_r;
      p2_neg_r <= {4'(5'd14 - 5'(p1_e_r)), 16'd0} - 20'(log_tab[lprod[13 +: IDX_W]]);
      p3_z_r   <= p2_z_r;
      p3_one_r <= p2_one_r;
      p3_t_r   <= 28'((44'(p2_neg_r) * 44'(ctx_r[K_P3-1].pwr)) >> 16);
      fac_r    <= fac_nxt;
    end
  end

  // final mix
  logic [16:0] s_r [3];
  logic [20:0] m_r [3];
  logic [17:0] tot [3];
  logic [15:0] out_nxt [3];
  logic [15:0] out_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tot[i]     = 18'((22'(ctx_r[NS-1].amb[i]) + 22'(m_r[i])) >> 4);
      out_nxt[i] = (tot[i] > 18'hFFFF) ? 16'hFFFF : tot[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]   <= 17'((33'(ctx_r[K_S-1].spc[i]) * 33'(fac_r)) >> 16);
        m_r[i]   <= 21'((37'(21'(ctx_r[K_M-1].dif[i]) + 21'(s_r[i]))
                        * 37'(ctx_r[K_M-1].shadow)) >> 16);
        out_r[i] <= out_nxt[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

  a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
    vk_r[K_DIV-1] && !ctx_r[K_DIV-1].zero |->
      sqres_r[SQRT_STG-1] >= (63'd1 << 29) && sqres_r[SQRT_STG-1] < (63'd1 << 31))
    else $error("view length out of range");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    vk_r[K_U-1] && !ctx_r[K_U-1].zero |->
      dq_r[DIV_STG-1][0] <= 16'(ONE_Q14) && dq_r[DIV_STG-1][1] <= 16'(ONE_Q14)
      && dq_r[DIV_STG-1][2] <= 16'(ONE_Q14))
    else $error("view component above one");

  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vk_r[K_P4] |-> fac_r <= ONE_Q16)
    else $error("specular factor above one");

endmodule
